@@ rtl/ils_pkg.sv @@
// Package with the types, sizes and codes of the indexed list store.
`default_nettype none
package ils_pkg;

    localparam int DEPTH     = 16;
    localparam int ITEM_BITS = 32;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int LEN_BITS  = $clog2(DEPTH + 1);
    localparam int POS_BITS  = 5;
    localparam int WORD_BITS = 32;
    localparam int HIT_BITS  = 4;

    typedef enum logic [2:0] {
        K_PUSH   = 3'd0,
        K_POP    = 3'd1,
        K_GET    = 3'd2,
        K_SET    = 3'd3,
        K_INSERT = 3'd4,
        K_REMOVE = 3'd5,
        K_FIND   = 3'd6,
        K_CLEAR  = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_WRITE      = 2'd1,
        CELL_SHIFT_UP   = 2'd2,
        CELL_SHIFT_DOWN = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_kind                 kind;
        logic [POS_BITS-1:0]   position;
        logic [WORD_BITS-1:0]  item_in;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [WORD_BITS-1:0]  item_out;
        logic [HIT_BITS-1:0]   found_index;
        logic [LEN_BITS-1:0]   length;
    } t_out_item;

    typedef struct packed {
        t_cell_op              op;
        logic [ADDR_BITS-1:0]  addr;
        logic [LEN_BITS-1:0]   count;
        logic [ITEM_BITS-1:0]  word;
    } t_cell_ctrl;

endpackage
`default_nettype wire

@@ rtl/indexed_list_store_top.sv @@
// Top level of the indexed list store: operation decode, cell row and result register.
//
//   Channel   Direction   Handshake                 Payload
//   in        input       i_in_valid / o_in_ready   i_in  (t_in_item)
//   out       output      o_out_valid / i_out_ready o_out (t_out_item)
//
// The result of each operation is registered and shows the cycle after the input
// transaction. The row of cells shifts the whole tail and compares every entry in the
// same cycle as the transaction, so a new transaction is taken each cycle while the result
// register is empty or being drained. Reset clears the length and the result valid.
// A stalled result blocks new input until it is taken.
`default_nettype none
module indexed_list_store_top
    import ils_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out
);

    logic [LEN_BITS-1:0]  r_count;
    logic [LEN_BITS-1:0]  n_count;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;
    t_cell_ctrl           w_ctrl;
    t_cell_op             w_op;
    logic [ADDR_BITS-1:0] w_addr;
    logic [ADDR_BITS-1:0] w_rd_addr;
    logic [ITEM_BITS-1:0] w_rd_value;
    logic [ITEM_BITS-1:0] w_word;
    logic [ADDR_BITS-1:0] w_found;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_pos_ge;
    logic                 w_pos_gt;

    logic [ITEM_BITS-1:0] w_cell_value [DEPTH];
    logic                 w_hit        [DEPTH+1];
    logic                 w_first      [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_word     = i_in.item_in[ITEM_BITS-1:0];
    assign w_full     = (r_count >= LEN_BITS'(DEPTH));
    assign w_pos_ge   = ({1'b0, i_in.position} >= {1'b0, r_count});
    assign w_pos_gt   = ({1'b0, i_in.position} > {1'b0, r_count});
    assign w_rd_addr  = (i_in.kind == K_POP) ? ADDR_BITS'(r_count - 1'b1)
                                             : i_in.position[ADDR_BITS-1:0];
    assign w_rd_value = w_cell_value[w_rd_addr];

    assign w_ctrl.op    = w_accept ? w_op : CELL_HOLD;
    assign w_ctrl.addr  = w_addr;
    assign w_ctrl.count = r_count;
    assign w_ctrl.word  = w_word;

    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ITEM_BITS-1:0] w_prev;
        logic [ITEM_BITS-1:0] w_next;

        if (g == 0) begin : g_head
            assign w_prev = w_cell_value[g];
        end else begin : g_body
            assign w_prev = w_cell_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_next = w_cell_value[g];
        end else begin : g_inner
            assign w_next = w_cell_value[g+1];
        end

        ils_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (ADDR_BITS'(g)),
            .i_ctrl       (w_ctrl),
            .i_prev_value (w_prev),
            .i_next_value (w_next),
            .i_hit_in     (w_hit[g]),
            .o_hit_out    (w_hit[g+1]),
            .o_first      (w_first[g]),
            .o_value      (w_cell_value[g])
        );
    end

    always_comb begin
        w_found = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_first[k]) begin
                w_found = w_found | ADDR_BITS'(k);
            end
        end
    end

    always_comb begin
        w_op              = CELL_HOLD;
        w_addr            = i_in.position[ADDR_BITS-1:0];
        n_count           = r_count;
        n_out.status      = ST_OK;
        n_out.item_out    = '0;
        n_out.found_index = '0;
        unique case (i_in.kind)
            K_PUSH: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_op    = CELL_WRITE;
                    w_addr  = r_count[ADDR_BITS-1:0];
                    n_count = r_count + 1'b1;
                end
            end
            K_POP: begin
                if (r_count == '0) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_count        = r_count - 1'b1;
                    n_out.item_out = WORD_BITS'(w_rd_value);
                end
            end
            K_GET: begin
                if (w_pos_ge) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.item_out = WORD_BITS'(w_rd_value);
                end
            end
            K_SET: begin
                if (w_pos_ge) begin
                    n_out.status = ST_RANGE;
                end else begin
                    w_op = CELL_WRITE;
                end
            end
            K_INSERT: begin
                if (w_pos_gt) begin
                    n_out.status = ST_RANGE;
                end else if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_op    = CELL_SHIFT_UP;
                    n_count = r_count + 1'b1;
                end
            end
            K_REMOVE: begin
                if (w_pos_ge) begin
                    n_out.status = ST_RANGE;
                end else begin
                    w_op           = CELL_SHIFT_DOWN;
                    n_count        = r_count - 1'b1;
                    n_out.item_out = WORD_BITS'(w_rd_value);
                end
            end
            K_FIND: begin
                if (w_hit[DEPTH]) begin
                    n_out.found_index = HIT_BITS'(w_found);
                end else begin
                    n_out.status = ST_NOTFOUND;
                end
            end
            K_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.length = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

@@ rtl/ils_cell.sv @@
// One storage cell of the list: holds one entry, shifts with its neighbors and compares.
`default_nettype none
module ils_cell
    import ils_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic [ADDR_BITS-1:0] i_index,
    input  wire t_cell_ctrl           i_ctrl,
    input  wire logic [ITEM_BITS-1:0] i_prev_value,
    input  wire logic [ITEM_BITS-1:0] i_next_value,
    input  wire logic                 i_hit_in,
    output logic                      o_hit_out,
    output logic                      o_first,
    output logic [ITEM_BITS-1:0]      o_value
);

    logic [ITEM_BITS-1:0] r_value;
    logic [ITEM_BITS-1:0] n_value;
    logic                 w_match;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            CELL_WRITE: begin
                if (i_index == i_ctrl.addr) begin
                    n_value = i_ctrl.word;
                end
            end
            CELL_SHIFT_UP: begin
                if (i_index == i_ctrl.addr) begin
                    n_value = i_ctrl.word;
                end else if (i_index > i_ctrl.addr) begin
                    n_value = i_prev_value;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (i_index >= i_ctrl.addr) begin
                    n_value = i_next_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign w_match   = (r_value == i_ctrl.word) &&
                       ({1'b0, i_index} < {1'b0, i_ctrl.count});
    assign o_first   = w_match && !i_hit_in;
    assign o_hit_out = w_match || i_hit_in;
    assign o_value   = r_value;

endmodule
`default_nettype wire
